// ===== sv/cmne_pkg.sv =====
// ---------------------------------------------------------------------------
// cmne_pkg: shared types and constants
// Pixel, length and counter widths, register codes and the control word
// passed from the front end to the window back end.
// ---------------------------------------------------------------------------
package cmne_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int LEN_W       = 18;
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 16;
  localparam int ROW_W       = HEIGHT_W + 1;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam int DEF_RADIUS    = 1;
  localparam int DEF_MAX_WIDTH = 2048;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(480);

  localparam logic [PIX_W-1:0] WHITE_PIX = {PIX_W{1'b1}};
  localparam logic [LEN_W-1:0] WHITE_LEN = LEN_W'(3 * 255 * 255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 4'd0,
    CFG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic has_out;
    logic last;
  } ctl_t;

  function automatic logic [LEN_W-1:0] sq_len(input logic [PIX_W-1:0] px);
    logic [2*CH_W-1:0] s0;
    logic [2*CH_W-1:0] s1;
    logic [2*CH_W-1:0] s2;
    s0 = {{CH_W{1'b0}}, px[CH_W-1:0]} * {{CH_W{1'b0}}, px[CH_W-1:0]};
    s1 = {{CH_W{1'b0}}, px[2*CH_W-1:CH_W]} * {{CH_W{1'b0}}, px[2*CH_W-1:CH_W]};
    s2 = {{CH_W{1'b0}}, px[3*CH_W-1:2*CH_W]} * {{CH_W{1'b0}}, px[3*CH_W-1:2*CH_W]};
    return LEN_W'(s0) + LEN_W'(s1) + LEN_W'(s2);
  endfunction

endpackage

// ===== sv/color_min_norm_erode.sv =====
// ---------------------------------------------------------------------------
// color_min_norm_erode: vector erosion of a three-channel pixel stream
// Square window minimum by squared length over a raster pixel stream.
// ---------------------------------------------------------------------------
// Takes one pixel word per clock in raster order while tready is high and
// returns one output pixel per clock once RADIUS rows plus RADIUS pixels
// have entered; after the last pixel of a frame, RADIUS*(width+1) flush
// words (tuser high) push out the remaining outputs, the last one flagged by
// tlast. A flush word sent while pixels are still due is dropped. The front
// end writes each pixel into one of 2*RADIUS+2 row rams and reads one window
// column across all of them in the same cycle, so the sustained rate is one
// word per clock while the output side keeps up; the fetch register, a
// four-entry queue and a two-stage window/minimum back end lie between an
// accepted input word and the output word it releases. Writing either size
// register restarts the frame; write them only while the block is idle.
module color_min_norm_erode
  import cmne_pkg::*;
#(
  parameter int RADIUS    = DEF_RADIUS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [PIX_W-1:0]      s_axis_tdata_i,   // chan_0, chan_1, chan_2
  input  logic                  s_axis_tuser_i,   // flush
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [PIX_W-1:0]      m_axis_tdata_o,   // out_0, out_1, out_2
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SPAN = 2 * RADIUS + 1;
  localparam int IW   = $clog2(SPAN);
  localparam int EW   = SPAN * IW + $bits(ctl_t) + SPAN * PIX_W;

  logic                  push;
  ctl_t                  push_ctl;
  logic [SPAN*IW-1:0]    push_idx;
  logic [SPAN*PIX_W-1:0] push_col;
  logic                  q_valid;
  logic                  q_pop;
  logic [EW-1:0]         q_data;
  logic [FIFO_CNT_W-1:0] q_cnt;

  assign cfg_ready_o = 1'b1;

  cmne_front #(
    .RADIUS   (RADIUS),
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .s_pix_i    (s_axis_tdata_i),
    .s_flush_i  (s_axis_tuser_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fifo_cnt_i (q_cnt),
    .push_o     (push),
    .push_ctl_o (push_ctl),
    .push_idx_o (push_idx),
    .push_col_o (push_col)
  );

  cmne_fifo #(
    .WIDTH(EW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({push_idx, push_ctl, push_col}),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_data),
    .count_o(q_cnt)
  );

  cmne_back #(
    .RADIUS(RADIUS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_pop_o  (q_pop),
    .q_ctl_i  (q_data[SPAN*PIX_W +: $bits(ctl_t)]),
    .q_idx_i  (q_data[EW-1 -: SPAN*IW]),
    .q_col_i  (q_data[SPAN*PIX_W-1:0]),
    .m_valid_o(m_axis_tvalid_o),
    .m_ready_i(m_axis_tready_i),
    .m_pix_o  (m_axis_tdata_o),
    .m_last_o (m_axis_tlast_o)
  );

endmodule

// ===== sv/cmne_ram.sv =====
// ---------------------------------------------------------------------------
// cmne_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module cmne_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cmne_fifo.sv =====
// ---------------------------------------------------------------------------
// cmne_fifo: small register queue
// Decouples the line store front end from the window back end.
// ---------------------------------------------------------------------------
module cmne_fifo
  import cmne_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      data_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  localparam int PW = $clog2(FIFO_DEPTH);

  logic [WIDTH-1:0]      buf_q [FIFO_DEPTH];
  logic [PW-1:0]         wr_q, wr_d;
  logic [PW-1:0]         rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== sv/cmne_front.sv =====
// ---------------------------------------------------------------------------
// cmne_front: input side, line store and column fetch
// Takes pixel words, writes them to the line store, reads one clamped
// column of the window per advancing word and tags it for the back end.
// ---------------------------------------------------------------------------
module cmne_front
  import cmne_pkg::*;
#(
  parameter int RADIUS    = DEF_RADIUS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            s_valid_i,
  output logic                                            s_ready_o,
  input  logic [PIX_W-1:0]                                s_pix_i,
  input  logic                                            s_flush_i,
  input  logic                                            cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                            cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                           cfg_data_i,
  input  logic [FIFO_CNT_W-1:0]                           fifo_cnt_i,
  output logic                                            push_o,
  output ctl_t                                            push_ctl_o,
  output logic [(2*RADIUS+1)*$clog2(2*RADIUS+1)-1:0]      push_idx_o,
  output logic [(2*RADIUS+1)*PIX_W-1:0]                   push_col_o
);

  localparam int SPAN  = 2 * RADIUS + 1;
  localparam int SLOTS = 2 * RADIUS + 2;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int IW    = $clog2(SPAN);
  localparam int LAG_W = $clog2(RADIUS * (MAX_WIDTH + 1) + 1);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [EW-1:0]       eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [LAG_W-1:0]    lag_tgt;

  logic [CW-1:0]       in_col_q;
  logic [ROW_W-1:0]    in_row_q;
  logic [SW-1:0]       in_slot_q;
  logic                drain_q;
  logic [LAG_W-1:0]    lag_cnt_q;
  logic [CW-1:0]       out_col_q;
  logic [HEIGHT_W-1:0] out_row_q;

  logic                accept;
  logic                adv;
  logic                has_out;
  logic                is_last;
  logic                in_wrap;
  logic                out_wrap;

  logic                f1_valid_q;
  ctl_t                f1_ctl_q;
  logic [SPAN*IW-1:0]  f1_idx_q;
  logic [SPAN*IW-1:0]  idx_d;
  logic                f1_byp_q [SPAN];
  logic                byp_d [SPAN];
  logic [SW-1:0]       f1_slot_q [SPAN];
  logic [SW-1:0]       slot_d [SPAN];
  logic [PIX_W-1:0]    f1_pix_q;
  logic [PIX_W-1:0]    rdata [SLOTS];

  logic signed [ROW_W+1:0] u;
  logic [ROW_W-1:0]        hm1;
  logic [ROW_W-1:0]        rr;
  logic [ROW_W-1:0]        bdist;
  logic [SW-1:0]           bsel;
  logic [SW:0]             stmp;
  logic signed [CW+2:0]    oc;
  logic signed [CW+2:0]    cc;
  logic signed [CW+2:0]    wm1;
  logic signed [CW+2:0]    ix;

  // effective frame size
  always_comb begin
    if (width_q == '0) begin
      eff_w = EW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_q);
    end
    eff_h   = (height_q == '0) ? HEIGHT_W'(1) : height_q;
    lag_tgt = LAG_W'(RADIUS) * (LAG_W'(eff_w) + LAG_W'(1));
  end

  assign s_ready_o = (32'(fifo_cnt_i) + 32'(f1_valid_q)) < FIFO_DEPTH;
  assign accept    = s_valid_i & s_ready_o;
  // a flush word while pixels are still due is dropped
  assign adv       = accept & ~(s_flush_i & ~drain_q);
  assign has_out   = (lag_cnt_q == lag_tgt);
  assign in_wrap   = (EW'(in_col_q) + EW'(1)) == eff_w;
  assign out_wrap  = (EW'(out_col_q) + EW'(1)) == eff_w;
  assign is_last   = has_out & out_wrap & (out_row_q == eff_h - HEIGHT_W'(1));

  // row selection for each window row of the fetched column
  always_comb begin
    hm1 = ROW_W'(eff_h) - ROW_W'(1);
    u = '0; rr = '0; bdist = '0; bsel = '0; stmp = '0;
    for (int t = 0; t < SPAN; t++) begin
      u = $signed({2'b00, in_row_q}) - (ROW_W+2)'(2 * RADIUS) + (ROW_W+2)'(t);
      if (u < 0) begin
        rr = '0;
      end else if (u > $signed({2'b00, hm1})) begin
        rr = hm1;
      end else begin
        rr = u[ROW_W-1:0];
      end
      bdist = in_row_q - rr;
      if (bdist > ROW_W'(2 * RADIUS)) begin
        bsel = SW'(2 * RADIUS);
      end else begin
        bsel = bdist[SW-1:0];
      end
      stmp = (SW+1)'(SLOTS) + {1'b0, in_slot_q} - {1'b0, bsel};
      if (in_slot_q >= bsel) begin
        slot_d[t] = in_slot_q - bsel;
      end else begin
        slot_d[t] = stmp[SW-1:0];
      end
      byp_d[t] = (bdist == '0);
    end
  end

  // column pick per window column, clamped to the row
  always_comb begin
    oc  = $signed((CW+3)'(out_col_q));
    wm1 = $signed((CW+3)'(eff_w)) - (CW+3)'(1);
    cc  = '0;
    ix  = '0;
    idx_d = '0;
    for (int j = 0; j < SPAN; j++) begin
      cc = oc + (CW+3)'(j - RADIUS);
      if (cc < 0) begin
        cc = '0;
      end else if (cc > wm1) begin
        cc = wm1;
      end
      ix = (CW+3)'(RADIUS) - (cc - oc);
      idx_d[j*IW +: IW] = ix[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= RESET_WIDTH;
      height_q   <= RESET_HEIGHT;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      drain_q    <= 1'b0;
      lag_cnt_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= adv;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
          default: ;
        endcase
        if (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          in_slot_q <= '0;
          drain_q   <= 1'b0;
          lag_cnt_q <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end
      end else if (adv) begin
        if (is_last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          in_slot_q <= '0;
          drain_q   <= 1'b0;
          lag_cnt_q <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end else begin
          if (in_wrap) begin
            in_col_q  <= '0;
            in_row_q  <= in_row_q + ROW_W'(1);
            in_slot_q <= (in_slot_q == SW'(SLOTS - 1)) ? '0 : in_slot_q + SW'(1);
            if (in_row_q == ROW_W'(eff_h) - ROW_W'(1)) begin
              drain_q <= 1'b1;
            end
          end else begin
            in_col_q <= in_col_q + CW'(1);
          end
          if (!has_out) begin
            lag_cnt_q <= lag_cnt_q + LAG_W'(1);
          end else if (out_wrap) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + HEIGHT_W'(1);
          end else begin
            out_col_q <= out_col_q + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_ctl_q.has_out <= has_out;
      f1_ctl_q.last    <= is_last;
      f1_idx_q         <= idx_d;
      f1_pix_q         <= s_pix_i;
      for (int t = 0; t < SPAN; t++) begin
        f1_byp_q[t]  <= byp_d[t];
        f1_slot_q[t] <= slot_d[t];
      end
    end
  end

  for (genvar s = 0; s < SLOTS; s++) begin : g_line
    cmne_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (adv & ~drain_q & (in_slot_q == SW'(s))),
      .waddr_i(in_col_q),
      .wdata_i(s_pix_i),
      .re_i   (adv),
      .raddr_i(in_col_q),
      .rdata_o(rdata[s])
    );
  end

  // current row comes straight from the registered input word
  always_comb begin
    for (int t = 0; t < SPAN; t++) begin
      push_col_o[t*PIX_W +: PIX_W] = f1_byp_q[t] ? f1_pix_q : rdata[f1_slot_q[t]];
    end
  end

  assign push_o     = f1_valid_q;
  assign push_ctl_o = f1_ctl_q;
  assign push_idx_o = f1_idx_q;

endmodule

// ===== sv/cmne_back.sv =====
// ---------------------------------------------------------------------------
// cmne_back: window and minimum search
// Shifts fetched columns into the window, picks the clamped columns and
// finds the first pixel of smallest squared length.
// ---------------------------------------------------------------------------
module cmne_back
  import cmne_pkg::*;
#(
  parameter int RADIUS = DEF_RADIUS
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        q_valid_i,
  output logic                                        q_pop_o,
  input  ctl_t                                        q_ctl_i,
  input  logic [(2*RADIUS+1)*$clog2(2*RADIUS+1)-1:0]  q_idx_i,
  input  logic [(2*RADIUS+1)*PIX_W-1:0]               q_col_i,
  output logic                                        m_valid_o,
  input  logic                                        m_ready_i,
  output logic [PIX_W-1:0]                            m_pix_o,
  output logic                                        m_last_o
);

  localparam int SPAN = 2 * RADIUS + 1;
  localparam int IW   = $clog2(SPAN);
  localparam int WIN  = SPAN * SPAN;
  localparam int NP   = 1 << $clog2(WIN);

  logic               en;
  logic [PIX_W-1:0]   sr_pix_q [SPAN][SPAN];
  logic [LEN_W-1:0]   sr_len_q [SPAN][SPAN];
  logic               b_valid_q;
  logic               b_last_q;
  logic [SPAN*IW-1:0] b_idx_q;
  logic               out_valid_q;
  logic [PIX_W-1:0]   out_pix_q;
  logic               out_last_q;
  logic [LEN_W-1:0]   tl [NP];
  logic [PIX_W-1:0]   tp [NP];
  logic [IW-1:0]      sel;

  assign en      = ~out_valid_q | m_ready_i;
  assign q_pop_o = en & q_valid_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      for (int t = 0; t < SPAN; t++) begin
        sr_pix_q[0][t] <= q_col_i[t*PIX_W +: PIX_W];
        sr_len_q[0][t] <= sq_len(q_col_i[t*PIX_W +: PIX_W]);
        for (int i = 1; i < SPAN; i++) begin
          sr_pix_q[i][t] <= sr_pix_q[i-1][t];
          sr_len_q[i][t] <= sr_len_q[i-1][t];
        end
      end
      b_last_q <= q_ctl_i.last;
      b_idx_q  <= q_idx_i;
    end
    if (en) begin
      out_pix_q  <= tp[0];
      out_last_q <= b_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q   <= q_valid_i & q_ctl_i.has_out;
      out_valid_q <= b_valid_q;
    end
  end

  // row-major window, lower position wins a tie
  always_comb begin
    sel = '0;
    for (int k = 0; k < NP; k++) begin
      tl[k] = WHITE_LEN;
      tp[k] = WHITE_PIX;
    end
    for (int t = 0; t < SPAN; t++) begin
      for (int j = 0; j < SPAN; j++) begin
        sel = b_idx_q[j*IW +: IW];
        tl[t*SPAN+j] = sr_len_q[sel][t];
        tp[t*SPAN+j] = sr_pix_q[sel][t];
      end
    end
    for (int s = 1; s < NP; s = s * 2) begin
      for (int i = 0; i < NP; i = i + 2 * s) begin
        if (tl[i+s] < tl[i]) begin
          tl[i] = tl[i+s];
          tp[i] = tp[i+s];
        end
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_pix_o   = out_pix_q;
  assign m_last_o  = out_last_q;

endmodule
